@@ rtl/core/pyuv_pkg.sv @@
// ----------------------------------------------------------------------------
// pyuv_pkg
// Shared types, constants and helpers for the packed 4:2:2 to RGB888 core.
// ----------------------------------------------------------------------------
package pyuv_pkg;

  localparam int SampleW = 8;
  localparam int DeltaW  = SampleW + 1;
  localparam int CoefW   = 18;
  localparam int ProdW   = 26;
  localparam int SumW    = 27;
  localparam int FracW   = 16;

  localparam logic signed [CoefW-1:0] QRV = 18'sd92242;
  localparam logic signed [CoefW-1:0] QGU = 18'sd22643;
  localparam logic signed [CoefW-1:0] QGV = 18'sd46983;
  localparam logic signed [CoefW-1:0] QBU = 18'sd116589;

  localparam logic [SampleW-1:0] ChromaMid = 8'd128;
  localparam logic [SampleW-1:0] ChanMax   = 8'd255;

  typedef enum logic [1:0] {
    ORDER_YUYV = 2'd0,
    ORDER_UYVY = 2'd1,
    ORDER_YVYU = 2'd2,
    ORDER_VYUY = 2'd3
  } byte_order_t;

  typedef struct packed {
    logic valid;
    logic line_end;
    logic frame_end;
  } ctrl_t;

  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
  } pixel_t;

  function automatic logic [SampleW-1:0] clamp_q16(input logic signed [SumW-1:0] s);
    logic [SampleW-1:0] r;
    if (s[SumW-1]) begin
      r = '0;
    end else if (|s[SumW-2:FracW+SampleW]) begin
      r = ChanMax;
    end else begin
      r = s[FracW+SampleW-1:FracW];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pyuv_pipe.sv @@
// ----------------------------------------------------------------------------
// pyuv_pipe
// Three-stage arithmetic pipeline: unpack, chroma products, channel sums,
// with clamping on the way out.
// ----------------------------------------------------------------------------
module pyuv_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  pyuv_pkg::byte_order_t          order,
  input  pyuv_pkg::ctrl_t                in_ctrl,
  input  logic [pyuv_pkg::SampleW-1:0]   b0,
  input  logic [pyuv_pkg::SampleW-1:0]   b1,
  input  logic [pyuv_pkg::SampleW-1:0]   b2,
  input  logic [pyuv_pkg::SampleW-1:0]   b3,
  output pyuv_pkg::ctrl_t                out_ctrl,
  output pyuv_pkg::pixel_t               pix_a,
  output pyuv_pkg::pixel_t               pix_b
);

  localparam int SW = pyuv_pkg::SampleW;
  localparam int DW = pyuv_pkg::DeltaW;
  localparam int PW = pyuv_pkg::ProdW;
  localparam int NW = pyuv_pkg::SumW;
  localparam int FW = pyuv_pkg::FracW;

  logic [SW-1:0] y1_c, y2_c, u_c, v_c;

  always_comb begin
    case (order)
      pyuv_pkg::ORDER_YUYV: begin
        y1_c = b0; u_c = b1; y2_c = b2; v_c = b3;
      end
      pyuv_pkg::ORDER_UYVY: begin
        u_c = b0; y1_c = b1; v_c = b2; y2_c = b3;
      end
      pyuv_pkg::ORDER_YVYU: begin
        y1_c = b0; v_c = b1; y2_c = b2; u_c = b3;
      end
      default: begin
        v_c = b0; y1_c = b1; u_c = b2; y2_c = b3;
      end
    endcase
  end

  pyuv_pkg::ctrl_t s1_ctrl, s2_ctrl, s3_ctrl;
  logic [SW-1:0]        s1_y1, s1_y2, s2_y1, s2_y2;
  logic signed [DW-1:0] s1_du, s1_dv;
  logic signed [PW-1:0] s2_rv, s2_gu, s2_gv, s2_bu;
  logic signed [NW-1:0] s3_r1, s3_g1, s3_b1, s3_r2, s3_g2, s3_b2;

  logic signed [DW+pyuv_pkg::CoefW-1:0] m_rv, m_gu, m_gv, m_bu;
  logic signed [NW-1:0] base1, base2, e_rv, e_gu, e_gv, e_bu;

  assign m_rv = s1_dv * pyuv_pkg::QRV;
  assign m_gu = s1_du * pyuv_pkg::QGU;
  assign m_gv = s1_dv * pyuv_pkg::QGV;
  assign m_bu = s1_du * pyuv_pkg::QBU;

  assign base1 = $signed({{(NW-SW-FW){1'b0}}, s2_y1, {FW{1'b0}}});
  assign base2 = $signed({{(NW-SW-FW){1'b0}}, s2_y2, {FW{1'b0}}});
  assign e_rv  = NW'(s2_rv);
  assign e_gu  = NW'(s2_gu);
  assign e_gv  = NW'(s2_gv);
  assign e_bu  = NW'(s2_bu);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
      s2_ctrl <= '0;
      s3_ctrl <= '0;
    end else if (en) begin
      s1_ctrl <= in_ctrl;
      s2_ctrl <= s1_ctrl;
      s3_ctrl <= s2_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_y1 <= y1_c;
      s1_y2 <= y2_c;
      s1_du <= $signed({1'b0, u_c}) - $signed({1'b0, pyuv_pkg::ChromaMid});
      s1_dv <= $signed({1'b0, v_c}) - $signed({1'b0, pyuv_pkg::ChromaMid});

      s2_y1 <= s1_y1;
      s2_y2 <= s1_y2;
      s2_rv <= m_rv[PW-1:0];
      s2_gu <= m_gu[PW-1:0];
      s2_gv <= m_gv[PW-1:0];
      s2_bu <= m_bu[PW-1:0];

      s3_r1 <= base1 + e_rv;
      s3_g1 <= base1 - e_gu - e_gv;
      s3_b1 <= base1 + e_bu;
      s3_r2 <= base2 + e_rv;
      s3_g2 <= base2 - e_gu - e_gv;
      s3_b2 <= base2 + e_bu;
    end
  end

  assign out_ctrl    = s3_ctrl;
  assign pix_a.red   = pyuv_pkg::clamp_q16(s3_r1);
  assign pix_a.green = pyuv_pkg::clamp_q16(s3_g1);
  assign pix_a.blue  = pyuv_pkg::clamp_q16(s3_b1);
  assign pix_b.red   = pyuv_pkg::clamp_q16(s3_r2);
  assign pix_b.green = pyuv_pkg::clamp_q16(s3_g2);
  assign pix_b.blue  = pyuv_pkg::clamp_q16(s3_b2);

endmodule

@@ rtl/core/packed_yuv422_to_rgb_core.sv @@
// ----------------------------------------------------------------------------
// packed_yuv422_to_rgb_core
// Packed 4:2:2 macropixel to two RGB888 pixels, byte order set by register.
// Flow: unpack, product, sum and pair registers; the second pixel follows the first.
// New requests are taken while the pair register is empty or its second pixel leaves.
// Pipeline: unpack, products, sums, then a pair register sends pixels in turn.
// Reset: rst clears the valid bits, the output phase and byte_order (YUYV).
// ----------------------------------------------------------------------------
module packed_yuv422_to_rgb_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pyuv_pkg::SampleW-1:0] byte_zero,
  input  logic [pyuv_pkg::SampleW-1:0] byte_one,
  input  logic [pyuv_pkg::SampleW-1:0] byte_two,
  input  logic [pyuv_pkg::SampleW-1:0] byte_three,
  input  logic                         line_end,
  input  logic                         frame_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pyuv_pkg::SampleW-1:0] red,
  output logic [pyuv_pkg::SampleW-1:0] green,
  output logic [pyuv_pkg::SampleW-1:0] blue,
  output logic                         second_of_pair,
  output logic                         line_done,
  output logic                         frame_done
);

  pyuv_pkg::byte_order_t byte_order;
  pyuv_pkg::ctrl_t       in_ctrl, pipe_ctrl;
  pyuv_pkg::pixel_t      pipe_a, pipe_b, hold_a, hold_b;
  logic                  en, phase, full, hold_le, hold_fe;

  assign en       = !full || (out_ready && phase);
  assign in_ready = en;

  assign in_ctrl.valid     = in_valid;
  assign in_ctrl.line_end  = line_end;
  assign in_ctrl.frame_end = frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= pyuv_pkg::ORDER_YUYV;
    end else if (cfg_we) begin
      byte_order <= pyuv_pkg::byte_order_t'(cfg_wdata);
    end
  end

  pyuv_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .order    (byte_order),
    .in_ctrl  (in_ctrl),
    .b0       (byte_zero),
    .b1       (byte_one),
    .b2       (byte_two),
    .b3       (byte_three),
    .out_ctrl (pipe_ctrl),
    .pix_a    (pipe_a),
    .pix_b    (pipe_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      phase <= 1'b0;
    end else if (en) begin
      full  <= pipe_ctrl.valid;
      phase <= 1'b0;
    end else if (out_ready) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hold_a  <= pipe_a;
      hold_b  <= pipe_b;
      hold_le <= pipe_ctrl.line_end;
      hold_fe <= pipe_ctrl.frame_end;
    end
  end

  assign out_valid      = full;
  assign red            = phase ? hold_b.red   : hold_a.red;
  assign green          = phase ? hold_b.green : hold_a.green;
  assign blue           = phase ? hold_b.blue  : hold_a.blue;
  assign second_of_pair = phase;
  assign line_done      = phase & hold_le;
  assign frame_done     = phase & hold_fe;

endmodule
